@@ rtl/scr_pkg.sv @@
// Package with the shared types, selector slot codes and constant tables of the CP15 block.
package scr_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned BankSize = 24;
  localparam int unsigned BankIdxW = $clog2(BankSize);
  localparam int unsigned SlotW    = 6;
  localparam int unsigned RoIdxW   = 4;

  // Slot codes. Slots below BankSize live in the writable bank.
  localparam logic [SlotW-1:0] SlotRoBase   = 6'd24;
  localparam logic [SlotW-1:0] SlotMainId   = 6'd24;
  localparam logic [SlotW-1:0] SlotTlbType  = 6'd25;
  localparam logic [SlotW-1:0] SlotMmfr0    = 6'd26;
  localparam logic [SlotW-1:0] SlotIsar0    = 6'd27;
  localparam logic [SlotW-1:0] SlotSilicon  = 6'd35;
  localparam logic [SlotW-1:0] SlotTpidUro  = 6'd36;
  localparam logic [SlotW-1:0] SlotTpidUrw  = 6'd22;

  // Bank slots with a non-zero reset value.
  localparam logic [BankIdxW-1:0] BankCtrl     = 5'd0;
  localparam logic [BankIdxW-1:0] BankAuxCtrl  = 5'd1;
  localparam logic [BankIdxW-1:0] BankPrrr     = 5'd16;
  localparam logic [BankIdxW-1:0] BankNmrr     = 5'd17;

  localparam logic [DataW-1:0] CtrlReset    = 32'h00C5_0078;
  localparam logic [DataW-1:0] AuxCtrlReset = 32'h0000_0002;
  localparam logic [DataW-1:0] PrrrReset    = 32'h0009_8AA4;
  localparam logic [DataW-1:0] NmrrReset    = 32'h44E0_48E0;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNDEF  = 2'd1,
    ST_UNIMPL = 2'd2,
    ST_TLB    = 2'd3
  } scr_status_e;

  // Decision for one access, passed from the decoder to the top level.
  typedef struct packed {
    logic                bank_we;
    logic [BankIdxW-1:0] bank_idx;
    scr_status_e         status;
  } scr_access_t;

  function automatic logic [DataW-1:0] bank_reset(input logic [BankIdxW-1:0] idx);
    logic [DataW-1:0] val;
    case (idx)
      BankCtrl:    val = CtrlReset;
      BankAuxCtrl: val = AuxCtrlReset;
      BankPrrr:    val = PrrrReset;
      BankNmrr:    val = NmrrReset;
      default:     val = '0;
    endcase
    return val;
  endfunction

  // Read-only ID values, indexed by slot minus SlotRoBase.
  function automatic logic [DataW-1:0] ro_value(input logic [RoIdxW-1:0] idx);
    logic [DataW-1:0] val;
    case (idx)
      4'd0:    val = 32'h413F_C082;
      4'd1:    val = 32'h0020_2001;
      4'd2:    val = 32'h0110_0003;
      4'd3:    val = 32'h0010_1111;
      4'd4:    val = 32'h1311_2111;
      4'd5:    val = 32'h2123_2031;
      4'd6:    val = 32'h1111_2131;
      4'd7:    val = 32'h0001_1142;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/scr_in_if.sv @@
// Interface carrying one coprocessor access beat with a valid/ready handshake.
interface scr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        privilege;
  logic [2:0]  opcode_one;
  logic [2:0]  opcode_two;
  logic [3:0]  primary_reg;
  logic [3:0]  secondary_reg;
  logic [31:0] write_data;

  modport source (
    output valid, command, privilege, opcode_one, opcode_two,
           primary_reg, secondary_reg, write_data,
    input  ready
  );
  modport sink (
    input  valid, command, privilege, opcode_one, opcode_two,
           primary_reg, secondary_reg, write_data,
    output ready
  );
endinterface

@@ rtl/scr_out_if.sv @@
// Interface carrying one access result beat with a valid/ready handshake.
interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (
    output valid, read_data, status,
    input  ready
  );
  modport sink (
    input  valid, read_data, status,
    output ready
  );
endinterface

@@ rtl/scr_bank.sv @@
// Bank of the 24 writable system control registers with reset defaults.
module scr_bank
  import scr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [BankIdxW-1:0] idx_i,
  input  logic [DataW-1:0]    wdata_i,
  output logic [DataW-1:0]    rdata_o
);

  logic [DataW-1:0] bank_q [BankSize];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BankSize; i++) begin
        bank_q[i] <= bank_reset(BankIdxW'(i));
      end
    end else if (we_i) begin
      bank_q[idx_i] <= wdata_i;
    end
  end

  assign rdata_o = bank_q[idx_i];

endmodule

@@ rtl/scr_access.sv @@
// Selector decode, permission check and read data selection for one access.
module scr_access
  import scr_pkg::*;
(
  input  logic             command_i,
  input  logic             privilege_i,
  input  logic [2:0]       opcode_one_i,
  input  logic [2:0]       opcode_two_i,
  input  logic [3:0]       primary_reg_i,
  input  logic [3:0]       secondary_reg_i,
  input  logic [DataW-1:0] bank_rdata_i,
  input  logic [DataW-1:0] silicon_id_i,
  output scr_access_t      access_o,
  output logic [DataW-1:0] rdata_o
);

  logic             mapped;
  logic [SlotW-1:0] slot;
  logic             in_bank;
  logic             perm_ok;
  logic [DataW-1:0] slot_val;
  logic [2:0]       o1;
  logic [2:0]       o2;
  logic [3:0]       n;
  logic [3:0]       m;

  assign o1 = opcode_one_i;
  assign o2 = opcode_two_i;
  assign n  = primary_reg_i;
  assign m  = secondary_reg_i;

  always_comb begin
    mapped = 1'b0;
    slot   = '0;
    if (n == 4'd0) begin
      if (o1 == 3'd0 && m == 4'd0 && (o2 inside {3'd0, 3'd4, 3'd6, 3'd7})) begin
        mapped = 1'b1;
        slot   = SlotMainId;
      end else if (o1 == 3'd0 && m == 4'd0 && o2 == 3'd3) begin
        mapped = 1'b1;
        slot   = SlotTlbType;
      end else if (o1 == 3'd0 && m == 4'd1 && o2 == 3'd4) begin
        mapped = 1'b1;
        slot   = SlotMmfr0;
      end else if (o1 == 3'd0 && m == 4'd2) begin
        mapped = 1'b1;
        slot   = SlotIsar0 + SlotW'(o2);
      end else if (o1 == 3'd1 && m == 4'd0 && o2 == 3'd7) begin
        mapped = 1'b1;
        slot   = SlotSilicon;
      end
    end else if (o1 == 3'd0) begin
      case (n)
        4'd1: begin
          if (m == 4'd0 && o2 < 3'd3) begin
            mapped = 1'b1;
            slot   = SlotW'(o2);
          end else if (m == 4'd1 && o2 < 3'd3) begin
            mapped = 1'b1;
            slot   = 6'd3 + SlotW'(o2);
          end
        end
        4'd2: begin
          if (m == 4'd0 && o2 < 3'd3) begin
            mapped = 1'b1;
            slot   = 6'd6 + SlotW'(o2);
          end
        end
        4'd3: begin
          if (m == 4'd0 && o2 == 3'd0) begin
            mapped = 1'b1;
            slot   = 6'd9;
          end
        end
        4'd5: begin
          if (m < 4'd2 && o2 < 3'd2) begin
            mapped = 1'b1;
            slot   = 6'd10 + {4'd0, m[0], o2[0]};
          end
        end
        4'd6: begin
          if (m == 4'd0 && o2 == 3'd0) begin
            mapped = 1'b1;
            slot   = 6'd14;
          end else if (m == 4'd0 && o2 == 3'd2) begin
            mapped = 1'b1;
            slot   = 6'd15;
          end
        end
        4'd10: begin
          if (m == 4'd2 && o2 < 3'd2) begin
            mapped = 1'b1;
            slot   = 6'd16 + SlotW'(o2);
          end
        end
        4'd12: begin
          if (m == 4'd0 && o2 < 3'd2) begin
            mapped = 1'b1;
            slot   = 6'd18 + SlotW'(o2);
          end
        end
        4'd13: begin
          if (m == 4'd0 && o2 < 3'd3) begin
            mapped = 1'b1;
            slot   = 6'd20 + SlotW'(o2);
          end else if (m == 4'd0 && o2 == 3'd3) begin
            mapped = 1'b1;
            slot   = SlotTpidUro;
          end else if (m == 4'd0 && o2 == 3'd4) begin
            mapped = 1'b1;
            slot   = 6'd23;
          end
        end
        default: begin
          mapped = 1'b0;
        end
      endcase
    end
  end

  assign in_bank = (slot < SlotRoBase);

  // User level may touch only the user thread ID registers and write only the
  // read/write one; privileged level reads everything mapped and writes only the bank.
  always_comb begin
    if (command_i) begin
      perm_ok = privilege_i ? in_bank : (slot == SlotTpidUrw);
    end else begin
      perm_ok = privilege_i || slot == SlotTpidUrw || slot == SlotTpidUro;
    end
  end

  always_comb begin
    if (in_bank) begin
      slot_val = bank_rdata_i;
    end else if (slot == SlotSilicon) begin
      slot_val = silicon_id_i;
    end else begin
      slot_val = ro_value(RoIdxW'(slot - SlotRoBase));
    end
  end

  always_comb begin
    access_o.bank_idx = in_bank ? slot[BankIdxW-1:0] : '0;
    access_o.bank_we  = 1'b0;
    rdata_o           = '0;
    if (command_i && n == 4'd8) begin
      access_o.status = ST_TLB;
    end else if (!mapped) begin
      access_o.status = ST_UNIMPL;
    end else if (command_i) begin
      access_o.bank_we = perm_ok;
      access_o.status  = perm_ok ? ST_OK : ST_UNDEF;
    end else begin
      // A denied read still returns the register value.
      rdata_o         = slot_val;
      access_o.status = perm_ok ? ST_OK : ST_UNDEF;
    end
  end

endmodule

@@ rtl/system_control_coprocessor_regs_unit.sv @@
// Top level of the system control coprocessor register file.
//
// This block serves coprocessor register accesses in the style of CP15: each
// input beat is one read or write at user or privileged level, addressed by
// opcode_one, opcode_two, primary_reg and secondary_reg. Each beat produces
// exactly one result beat with read_data and a status code (ok, undefined
// instruction trap, unimplemented register, TLB operation ignored). The block
// accepts one beat per clock cycle while the result side does not stall it.
// The beat is captured in an input register. It is decoded from there and
// applied to the register bank as it moves on, and its result is held in an
// output register. The rate is set by the combinational decode and bank access
// between these two registers. A write updates the bank as its result moves
// into the output register, so the next access already sees the new value.
// Back-pressure on the result side stalls the input register. A new beat is
// still taken while a finished result waits, as long as the input register is
// empty. The silicon ID value is written through cfg_we_i and cfg_wdata_i
// and must be written only while no access is in flight.
module system_control_coprocessor_regs_unit
  import scr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  scr_in_if.sink           in_i,
  scr_out_if.source        out_o
);

  // Silicon ID configuration register.
  logic [DataW-1:0] silicon_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silicon_id_q <= '0;
    end else if (cfg_we_i) begin
      silicon_id_q <= cfg_wdata_i;
    end
  end

  // Input register stage. Only the valid flag is reset; the payload is
  // loaded on every accepted beat.
  logic             s1_valid_q;
  logic             s1_command_q;
  logic             s1_privilege_q;
  logic [2:0]       s1_opcode_one_q;
  logic [2:0]       s1_opcode_two_q;
  logic [3:0]       s1_primary_reg_q;
  logic [3:0]       s1_secondary_reg_q;
  logic [DataW-1:0] s1_write_data_q;

  // Output register stage.
  logic             out_valid_q;
  logic [DataW-1:0] out_rdata_q;
  scr_status_e      out_status_q;

  logic             out_free;
  logic             s1_move;
  logic             in_take;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign in_take  = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_command_q       <= in_i.command;
      s1_privilege_q     <= in_i.privilege;
      s1_opcode_one_q    <= in_i.opcode_one;
      s1_opcode_two_q    <= in_i.opcode_two;
      s1_primary_reg_q   <= in_i.primary_reg;
      s1_secondary_reg_q <= in_i.secondary_reg;
      s1_write_data_q    <= in_i.write_data;
    end
  end

  // Decode, permission check and register bank access for the beat held in
  // the input register.
  scr_access_t      access;
  logic [DataW-1:0] bank_rdata;
  logic [DataW-1:0] acc_rdata;
  logic             bank_we;

  scr_access u_access (
    .command_i       (s1_command_q),
    .privilege_i     (s1_privilege_q),
    .opcode_one_i    (s1_opcode_one_q),
    .opcode_two_i    (s1_opcode_two_q),
    .primary_reg_i   (s1_primary_reg_q),
    .secondary_reg_i (s1_secondary_reg_q),
    .bank_rdata_i    (bank_rdata),
    .silicon_id_i    (silicon_id_q),
    .access_o        (access),
    .rdata_o         (acc_rdata)
  );

  // The bank is written at most once per beat, only for a permitted write, as its result is committed.
  assign bank_we = s1_move && access.bank_we;

  scr_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (bank_we),
    .idx_i   (access.bank_idx),
    .wdata_i (s1_write_data_q),
    .rdata_o (bank_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_rdata_q  <= acc_rdata;
      out_status_q <= access.status;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_rdata_q;
  assign out_o.status    = out_status_q;

  // A write beat never returns read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_command_q) |=> (out_rdata_q == '0))
    else $error("write beat produced non-zero read data");

  // A trapped or ignored access never changes the bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (access.status == ST_UNDEF || access.status == ST_TLB ||
                    access.status == ST_UNIMPL)) |-> !access.bank_we)
    else $error("bank write enabled on a failed access");

  // With the result register empty the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while the result register is empty");

  // A committed beat always shows up as a valid result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("committed beat lost before the result register");

endmodule

@@ sim/system_control_coprocessor_regs_unit_test.sv @@
// Self-checking testbench for the system control coprocessor register file.
module system_control_coprocessor_regs_unit_test
  import scr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Access encodings on the input beat.
  localparam logic CmdRead    = 1'b0;
  localparam logic CmdWrite   = 1'b1;
  localparam logic PrivUser   = 1'b0;
  localparam logic PrivKernel = 1'b1;

  // A write with this primary register is a TLB maintenance operation.
  localparam logic [3:0] TlbCrn = 4'd8;

  // Bank positions of the writable registers, grouped as the selectors decode them.
  localparam int NoSlot      = -1;
  localparam int SlotSctlr   = 0;
  localparam int SlotSecCfg  = 3;
  localparam int SlotTtbr0   = 6;
  localparam int SlotDacr    = 9;
  localparam int SlotFsrBase = 10;
  localparam int SlotDfar    = 14;
  localparam int SlotIfar    = 15;
  localparam int SlotPrrr    = 16;
  localparam int SlotVbar    = 18;
  localparam int SlotFcseid  = 20;
  localparam int SlotTpidPrw = 23;

  // Run control. The limit is many times the slowest legal run of about 400 beats.
  localparam int HoldCycles = 80;
  localparam int CycleLimit = 200000;
  localparam int TailCycles = 10;

  typedef struct {
    logic        command;
    logic        privilege;
    logic [2:0]  opcode_one;
    logic [2:0]  opcode_two;
    logic [3:0]  primary_reg;
    logic [3:0]  secondary_reg;
    logic [31:0] write_data;
  } access_t;

  typedef struct {
    logic [31:0] read_data;
    scr_status_e status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [DataW-1:0] cfg_wdata;

  scr_in_if  in_if ();
  scr_out_if out_if ();

  system_control_coprocessor_regs_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow copy of the register state, kept in step with every accepted beat.
  logic [31:0] bank_model [BankSize];
  logic [31:0] silicon_model;

  // Results owed by the block, oldest first.
  result_t pending_results [$];
  // Every selector combination that hits a register, for well-formed traffic.
  access_t mapped_regs [$];

  int   mismatches = 0;
  int   cycle_count = 0;
  logic bubbles_enabled = 1'b0;
  logic hold_results = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run guard: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("system_control_coprocessor_regs_unit_test failed");
      $finish;
    end
  end

  // Translates the four selector fields to a register slot. Slots below BankSize are
  // the writable bank; the rest are read-only ID registers, the silicon ID and the
  // user read-only thread ID.
  function automatic int map_selectors(input logic [2:0] op1, input logic [2:0] op2,
                                       input logic [3:0] crn, input logic [3:0] crm);
    int slot;
    slot = NoSlot;
    if (crn == 4'd0) begin
      // Several main ID selectors are aliases of the same register.
      if (op1 == 3'd0 && crm == 4'd0 &&
          (op2 == 3'd0 || op2 == 3'd4 || op2 == 3'd6 || op2 == 3'd7))
        slot = int'(SlotMainId);
      else if (op1 == 3'd0 && crm == 4'd0 && op2 == 3'd3)
        slot = int'(SlotTlbType);
      else if (op1 == 3'd0 && crm == 4'd1 && op2 == 3'd4)
        slot = int'(SlotMmfr0);
      else if (op1 == 3'd0 && crm == 4'd2)
        slot = int'(SlotIsar0) + int'(op2);
      else if (op1 == 3'd1 && crm == 4'd0 && op2 == 3'd7)
        slot = int'(SlotSilicon);
    end else if (op1 == 3'd0) begin
      case (crn)
        4'd1: begin
          if (crm == 4'd0 && op2 < 3'd3) slot = SlotSctlr + int'(op2);
          else if (crm == 4'd1 && op2 < 3'd3) slot = SlotSecCfg + int'(op2);
        end
        4'd2: if (crm == 4'd0 && op2 < 3'd3) slot = SlotTtbr0 + int'(op2);
        4'd3: if (crm == 4'd0 && op2 == 3'd0) slot = SlotDacr;
        4'd5: if (crm < 4'd2 && op2 < 3'd2) slot = SlotFsrBase + int'(crm) * 2 + int'(op2);
        4'd6: begin
          if (crm == 4'd0 && op2 == 3'd0) slot = SlotDfar;
          else if (crm == 4'd0 && op2 == 3'd2) slot = SlotIfar;
        end
        4'd10: if (crm == 4'd2 && op2 < 3'd2) slot = SlotPrrr + int'(op2);
        4'd12: if (crm == 4'd0 && op2 < 3'd2) slot = SlotVbar + int'(op2);
        4'd13: begin
          if (crm == 4'd0) begin
            if (op2 < 3'd3) slot = SlotFcseid + int'(op2);
            else if (op2 == 3'd3) slot = int'(SlotTpidUro);
            else if (op2 == 3'd4) slot = SlotTpidPrw;
          end
        end
        default: ;
      endcase
    end
    return slot;
  endfunction

  // Fixed identification values of the read-only slots.
  function automatic logic [31:0] id_register_value(input int slot);
    logic [31:0] val;
    case (slot)
      int'(SlotMainId):    val = 32'h413F_C082;
      int'(SlotTlbType):   val = 32'h0020_2001;
      int'(SlotMmfr0):     val = 32'h0110_0003;
      int'(SlotIsar0):     val = 32'h0010_1111;
      int'(SlotIsar0) + 1: val = 32'h1311_2111;
      int'(SlotIsar0) + 2: val = 32'h2123_2031;
      int'(SlotIsar0) + 3: val = 32'h1111_2131;
      int'(SlotIsar0) + 4: val = 32'h0001_1142;
      default:             val = '0;
    endcase
    return val;
  endfunction

  // Computes the result of one access and applies any permitted write to the shadow
  // bank. A denied read still returns the register value; a denied write leaves the
  // register alone and returns zero.
  function automatic result_t predict_access(input access_t a);
    result_t r;
    int      slot;
    logic    allowed;
    r.read_data = '0;
    r.status    = ST_OK;
    if (a.command == CmdWrite && a.primary_reg == TlbCrn) begin
      r.status = ST_TLB;
      return r;
    end
    slot = map_selectors(a.opcode_one, a.opcode_two, a.primary_reg, a.secondary_reg);
    if (slot == NoSlot) begin
      r.status = ST_UNIMPL;
    end else if (a.command == CmdWrite) begin
      allowed = (a.privilege == PrivKernel) ? (slot < int'(BankSize))
                                            : (slot == int'(SlotTpidUrw));
      if (allowed) bank_model[slot] = a.write_data;
      else r.status = ST_UNDEF;
    end else begin
      allowed = (a.privilege == PrivKernel) || slot == int'(SlotTpidUrw) ||
                slot == int'(SlotTpidUro);
      if (slot < int'(BankSize)) r.read_data = bank_model[slot];
      else if (slot == int'(SlotSilicon)) r.read_data = silicon_model;
      else r.read_data = id_register_value(slot);
      if (!allowed) r.status = ST_UNDEF;
    end
    return r;
  endfunction

  function automatic access_t coproc_op(input logic cmd, input logic priv,
                                        input logic [2:0] op1, input logic [2:0] op2,
                                        input logic [3:0] crn, input logic [3:0] crm,
                                        input logic [31:0] data);
    access_t a;
    a.command       = cmd;
    a.privilege     = priv;
    a.opcode_one    = op1;
    a.opcode_two    = op2;
    a.primary_reg   = crn;
    a.secondary_reg = crm;
    a.write_data    = data;
    return a;
  endfunction

  // Mostly well-formed traffic: four beats in five hit a real register, the rest
  // have fully random selectors and so may land on unmapped space or TLB operations.
  function automatic access_t random_access();
    access_t a;
    int      pick;
    a.command       = 1'($urandom_range(0, 1));
    a.privilege     = ($urandom_range(0, 3) != 0) ? PrivKernel : PrivUser;
    a.opcode_one    = 3'($urandom);
    a.opcode_two    = 3'($urandom);
    a.primary_reg   = 4'($urandom);
    a.secondary_reg = 4'($urandom);
    case ($urandom_range(0, 9))
      0:       a.write_data = '0;
      1:       a.write_data = '1;
      default: a.write_data = $urandom;
    endcase
    if ($urandom_range(0, 4) != 0) begin
      pick            = $urandom_range(0, mapped_regs.size() - 1);
      a.opcode_one    = mapped_regs[pick].opcode_one;
      a.opcode_two    = mapped_regs[pick].opcode_two;
      a.primary_reg   = mapped_regs[pick].primary_reg;
      a.secondary_reg = mapped_regs[pick].secondary_reg;
    end
    return a;
  endfunction

  // Offers one beat and returns at the falling edge after it is taken. Valid is left
  // high so back-to-back beats go out without a bubble; a gap lowers it first.
  task automatic send_access(input access_t a);
    if (bubbles_enabled && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_if.command       = a.command;
    in_if.privilege     = a.privilege;
    in_if.opcode_one    = a.opcode_one;
    in_if.opcode_two    = a.opcode_two;
    in_if.primary_reg   = a.primary_reg;
    in_if.secondary_reg = a.secondary_reg;
    in_if.write_data    = a.write_data;
    in_if.valid         = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_access(a));
    @(negedge clk_i);
  endtask

  // Stops sending and waits for every owed result, leaving the block idle.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The silicon ID may only change while nothing is in flight.
  task automatic write_silicon_id(input logic [31:0] value);
    drain_results();
    cfg_we        = 1'b1;
    cfg_wdata     = value;
    silicon_model = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Reads the registers whose reset value is not zero, plus a zero one.
  task automatic test_reset_values();
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd0, 4'd1, 4'd0, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd1, 4'd1, 4'd0, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd0, 4'd10, 4'd2, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd1, 4'd10, 4'd2, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd0, 4'd2, 4'd0, '0));
  endtask

  // Permission rules, aliases, read-only registers, TLB operations and unmapped space.
  task automatic test_access_rules();
    // Extremes of write data through the control register.
    send_access(coproc_op(CmdWrite, PrivKernel, 3'd0, 3'd0, 4'd1, 4'd0, 32'hFFFF_FFFF));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd0, 4'd1, 4'd0, '0));
    send_access(coproc_op(CmdWrite, PrivKernel, 3'd0, 3'd0, 4'd1, 4'd0, '0));
    // A user read of a privileged register traps but still returns its value.
    send_access(coproc_op(CmdRead, PrivUser, 3'd0, 3'd0, 4'd1, 4'd0, '0));
    // A user write traps and must not reach the register.
    send_access(coproc_op(CmdWrite, PrivUser, 3'd0, 3'd0, 4'd1, 4'd0, 32'h1234_5678));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd0, 4'd1, 4'd0, '0));
    // Main ID aliases; writing an ID register is denied even at privileged level.
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd7, 4'd0, 4'd0, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd6, 4'd0, 4'd0, '0));
    send_access(coproc_op(CmdWrite, PrivKernel, 3'd0, 3'd0, 4'd0, 4'd0, 32'hFFFF_FFFF));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd3, 4'd0, 4'd0, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd7, 4'd0, 4'd2, '0));
    // User thread ID registers: the read/write one works at user level, the
    // read-only one can never be written and reads zero.
    send_access(coproc_op(CmdWrite, PrivUser, 3'd0, 3'd2, 4'd13, 4'd0, 32'hA5A5_5A5A));
    send_access(coproc_op(CmdRead, PrivUser, 3'd0, 3'd2, 4'd13, 4'd0, '0));
    send_access(coproc_op(CmdWrite, PrivKernel, 3'd0, 3'd3, 4'd13, 4'd0, 32'hFFFF_FFFF));
    send_access(coproc_op(CmdWrite, PrivUser, 3'd0, 3'd3, 4'd13, 4'd0, 32'hFFFF_FFFF));
    send_access(coproc_op(CmdRead, PrivUser, 3'd0, 3'd3, 4'd13, 4'd0, '0));
    send_access(coproc_op(CmdWrite, PrivKernel, 3'd0, 3'd4, 4'd13, 4'd0, 32'h8000_0001));
    send_access(coproc_op(CmdRead, PrivUser, 3'd0, 3'd4, 4'd13, 4'd0, '0));
    // TLB maintenance writes are ignored; a read with the same primary register
    // is simply unmapped.
    send_access(coproc_op(CmdWrite, PrivKernel, 3'd0, 3'd0, TlbCrn, 4'd7, 32'hFFFF_FFFF));
    send_access(coproc_op(CmdWrite, PrivUser, 3'd7, 3'd7, TlbCrn, 4'd15, '0));
    send_access(coproc_op(CmdRead, PrivKernel, 3'd0, 3'd0, TlbCrn, 4'd7, '0));
    // Selector extremes fall outside every register.
    send_access(coproc_op(CmdRead, PrivKernel, 3'd7, 3'd7, 4'd15, 4'd15, '0));
    send_access(coproc_op(CmdWrite, PrivUser, 3'd7, 3'd7, 4'd15, 4'd15, 32'hFFFF_FFFF));
  endtask

  // The silicon ID through all-ones, zero and a random value, each read back.
  task automatic test_silicon_id();
    access_t rd;
    rd = coproc_op(CmdRead, PrivKernel, 3'd1, 3'd7, 4'd0, 4'd0, '0);
    send_access(rd);
    write_silicon_id(32'hFFFF_FFFF);
    send_access(rd);
    send_access(coproc_op(CmdRead, PrivUser, 3'd1, 3'd7, 4'd0, 4'd0, '0));
    write_silicon_id('0);
    send_access(rd);
    write_silicon_id($urandom);
    send_access(rd);
  endtask

  // Random traffic with bubbles on both sides and a new silicon ID every quarter.
  task automatic test_random_traffic();
    bubbles_enabled = 1'b1;
    for (int i = 0; i < 280; i++) begin
      if (i % 70 == 69) write_silicon_id($urandom);
      send_access(random_access());
    end
  endtask

  // The result side holds off for a long stretch while beats keep coming, so the
  // block fills and stalls its input; then the sender waits for everything owed.
  task automatic test_backpressure();
    hold_results = 1'b1;
    repeat (24) send_access(random_access());
    drain_results();
  endtask

  // Closing stretch at full rate with no bubbles on either side.
  task automatic test_full_rate();
    bubbles_enabled = 1'b0;
    repeat (60) send_access(random_access());
  endtask

  // Result receiver. A requested hold-off is counted here; otherwise ready drops in
  // short random bursts while bubbles are enabled.
  always begin
    @(negedge clk_i);
    if (hold_results) begin
      out_if.ready = 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      hold_results = 1'b0;
    end else if (bubbles_enabled && $urandom_range(0, 5) == 0) begin
      out_if.ready = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    out_if.ready = 1'b1;
  end

  // Result checker: every beat taken must match the oldest owed result.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with none owed: read_data %h status %0d",
               out_if.read_data, out_if.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_if.read_data);
          mismatches++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    access_t sel;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.command        = CmdRead;
    in_if.privilege      = PrivUser;
    in_if.opcode_one     = '0;
    in_if.opcode_two     = '0;
    in_if.primary_reg    = '0;
    in_if.secondary_reg  = '0;
    in_if.write_data     = '0;
    out_if.ready         = 1'b0;

    // Shadow state at reset: four registers have non-zero defaults.
    foreach (bank_model[i]) bank_model[i] = '0;
    bank_model[BankCtrl]    = CtrlReset;
    bank_model[BankAuxCtrl] = AuxCtrlReset;
    bank_model[BankPrrr]    = PrrrReset;
    bank_model[BankNmrr]    = NmrrReset;
    silicon_model           = '0;

    // Collect every selector combination that lands on a register.
    for (int s = 0; s < 16384; s++) begin
      sel = coproc_op(CmdRead, PrivKernel, 3'(s >> 11), 3'(s >> 8), 4'(s >> 4), 4'(s), '0);
      if (map_selectors(sel.opcode_one, sel.opcode_two, sel.primary_reg,
                        sel.secondary_reg) != NoSlot)
        mapped_regs.push_back(sel);
    end

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_access_rules();
    test_silicon_id();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    // Let the pipeline empty, then wait out a tail stretch to show any stray beat.
    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("system_control_coprocessor_regs_unit_test passed");
    end else begin
      $display("system_control_coprocessor_regs_unit_test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/scr_pkg.sv
rtl/scr_in_if.sv
rtl/scr_out_if.sv
rtl/scr_bank.sv
rtl/scr_access.sv
rtl/system_control_coprocessor_regs_unit.sv
sim/system_control_coprocessor_regs_unit_test.sv
